/* sv/psrq_pkg.sv */
package psrq_pkg;

    localparam int DefDepth    = 16;
    localparam int DefCoreBits = 4;
    localparam int DefAddrBits = 48;
    localparam int DefTagBits  = 8;

    typedef enum logic [1:0] {
        CMD_PUSH_TAIL = 2'd0,
        CMD_PUSH_HEAD = 2'd1,
        CMD_DEQUEUE   = 2'd2,
        CMD_QUERY     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Row-wide control, the same for every cell in one cycle
    typedef struct packed {
        logic push_tail;
        logic push_head;
        logic remove;
        logic strict;
    } t_cell_ctl;

endpackage

/* sv/psrq_cell.sv */
module psrq_cell
    import psrq_pkg::*;
#(
    parameter int DEPTH      = DefDepth,
    parameter int CORE_BITS  = DefCoreBits,
    parameter int ENTRY_BITS = DefCoreBits + DefAddrBits + DefTagBits,
    parameter int IDX        = 0,
    localparam int OccW      = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [OccW-1:0]       i_count,
    input  logic [CORE_BITS-1:0]  i_key,
    input  logic [ENTRY_BITS-1:0] i_new,
    input  logic [ENTRY_BITS-1:0] i_prev,
    input  logic [ENTRY_BITS-1:0] i_next,
    input  logic                  i_hit_seen,
    output logic                  o_hit_seen,
    output logic [ENTRY_BITS-1:0] o_sel,
    output logic [ENTRY_BITS-1:0] o_data
);

    localparam logic [OccW-1:0] MyPos  = OccW'(IDX);
    localparam bit              IsHead = (IDX == 0);

    logic [ENTRY_BITS-1:0] r_data;
    logic [ENTRY_BITS-1:0] n_data;
    logic                  occupied;
    logic                  hit;
    logic                  first;

    assign occupied = (MyPos < i_count);
    assign hit = occupied && (r_data[ENTRY_BITS-1 -: CORE_BITS] == i_key)
                 && (!i_ctl.strict || IsHead);
    assign first      = hit && !i_hit_seen;
    assign o_hit_seen = i_hit_seen || hit;
    assign o_sel      = first ? r_data : '0;
    assign o_data     = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push_head) begin
            n_data = i_prev;
        end else if (i_ctl.push_tail && (MyPos == i_count)) begin
            n_data = i_new;
        end else if (i_ctl.remove && o_hit_seen) begin
            // close the gap behind the removed request
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* sv/psrq_out_buf.sv */
module psrq_out_buf
    import psrq_pkg::*;
#(
    parameter int WIDTH = 2 + DefCoreBits + DefAddrBits + DefTagBits + 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_main;
    logic [WIDTH-1:0] r_skid;
    logic             take;

    assign take    = r_main_valid && !i_stall;
    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid && !r_skid_valid) begin
            if (!r_main_valid) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

/* sv/per_source_request_queue_unit.sv */
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_command i_core_id i_address i_msg_tag
// out       output     o_out_valid / i_out_stall o_status o_out_core o_out_address
//                                                o_out_tag o_occupancy
// cfg       input      i_cfg_we                  i_cfg_data (strict_order)
//
// One request per cycle while o_in_stall is low; its result is registered in the output buffer.
// The rate is bounded by the combinational update of the cell row, where the match flag
// ripples from head to tail through every cell.
// A two-deep output buffer holds results while the output stalls; o_in_stall rises
// only when both slots are full.
// Synchronous active-low reset empties the queue and clears strict_order.
module per_source_request_queue_unit
    import psrq_pkg::*;
#(
    parameter int DEPTH     = DefDepth,
    parameter int CORE_BITS = DefCoreBits,
    parameter int ADDR_BITS = DefAddrBits,
    parameter int TAG_BITS  = DefTagBits,
    localparam int OccW     = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [CORE_BITS-1:0] i_core_id,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [TAG_BITS-1:0]  i_msg_tag,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [CORE_BITS-1:0] o_out_core,
    output logic [ADDR_BITS-1:0] o_out_address,
    output logic [TAG_BITS-1:0]  o_out_tag,
    output logic [OccW-1:0]      o_occupancy
);

    localparam int EntW = CORE_BITS + ADDR_BITS + TAG_BITS;
    localparam int ResW = 2 + EntW + OccW;

    logic                r_strict;
    logic [OccW-1:0]     r_count;
    logic [OccW-1:0]     n_count;
    logic                accept;
    t_cmd                cmd;
    logic                full;
    logic                found;
    t_cell_ctl           ctl;
    t_status             status;
    logic [EntW-1:0]     new_entry;
    logic [EntW-1:0]     sel_or;
    logic [EntW-1:0]     deq_entry;
    logic [ResW-1:0]     result;
    logic [ResW-1:0]     out_data;
    logic [EntW-1:0]     cell_data [DEPTH];
    logic [EntW-1:0]     cell_sel  [DEPTH];
    logic [DEPTH:0]      hit_chain;

    assign accept    = i_in_valid && !o_in_stall;
    assign cmd       = t_cmd'(i_command);
    assign full      = (r_count == OccW'(DEPTH));
    assign found     = hit_chain[DEPTH];
    assign new_entry = {i_core_id, i_address, i_msg_tag};
    assign hit_chain[0] = 1'b0;

    assign ctl.push_tail = accept && (cmd == CMD_PUSH_TAIL) && !full;
    assign ctl.push_head = accept && (cmd == CMD_PUSH_HEAD) && !full;
    assign ctl.remove    = accept && (cmd == CMD_DEQUEUE) && found;
    assign ctl.strict    = r_strict;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [EntW-1:0] prev_data;
        logic [EntW-1:0] next_data;

        if (g == 0) begin : g_head
            assign prev_data = new_entry;
        end else begin : g_body
            assign prev_data = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign next_data = '0;
        end else begin : g_inner
            assign next_data = cell_data[g+1];
        end

        psrq_cell #(
            .DEPTH      (DEPTH),
            .CORE_BITS  (CORE_BITS),
            .ENTRY_BITS (EntW),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_count    (r_count),
            .i_key      (i_core_id),
            .i_new      (new_entry),
            .i_prev     (prev_data),
            .i_next     (next_data),
            .i_hit_seen (hit_chain[g]),
            .o_hit_seen (hit_chain[g+1]),
            .o_sel      (cell_sel[g]),
            .o_data     (cell_data[g])
        );
    end

    // Cells other than the first match drive zero, so a plain OR picks the entry
    always_comb begin
        sel_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            sel_or = sel_or | cell_sel[k];
        end
    end

    always_comb begin
        status    = ST_DONE;
        deq_entry = '0;
        n_count   = r_count;
        unique case (cmd)
            CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + OccW'(1);
                end
            end
            CMD_DEQUEUE: begin
                if (found) begin
                    deq_entry = sel_or;
                    n_count   = r_count - OccW'(1);
                end else begin
                    status = ST_NONE;
                end
            end
            CMD_QUERY: begin
                status = found ? ST_DONE : ST_NONE;
            end
            default: begin
                status = ST_NONE;
            end
        endcase
    end

    assign result = {status, deq_entry, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strict <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_strict <= i_cfg_data;
            end
        end
    end

    psrq_out_buf #(
        .WIDTH (ResW)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .o_stall (o_in_stall),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_status      = out_data[ResW-1 -: 2];
    assign o_out_core    = out_data[OccW+EntW-1 -: CORE_BITS];
    assign o_out_address = out_data[OccW+TAG_BITS+ADDR_BITS-1 -: ADDR_BITS];
    assign o_out_tag     = out_data[OccW+TAG_BITS-1 -: TAG_BITS];
    assign o_occupancy   = out_data[OccW-1:0];

endmodule

/* sv/psrq_checker.sv */
module psrq_checker
    import psrq_pkg::*;
#(
    parameter int DEPTH     = DefDepth,
    parameter int CORE_BITS = DefCoreBits,
    parameter int ADDR_BITS = DefAddrBits,
    parameter int TAG_BITS  = DefTagBits,
    localparam int OccW     = $clog2(DEPTH + 1)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_status,
    input logic [CORE_BITS-1:0] o_out_core,
    input logic [ADDR_BITS-1:0] o_out_address,
    input logic [TAG_BITS-1:0]  o_out_tag,
    input logic [OccW-1:0]      o_occupancy
);

    // occupancy never exceeds the row length
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= OccW'(DEPTH)))
        else $error("occupancy beyond depth");

    // a refused push only happens on a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_occupancy == OccW'(DEPTH)))
        else $error("full status with room left");

    // request fields are zero whenever the status is not done
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |->
        ((o_out_core == '0) && (o_out_address == '0) && (o_out_tag == '0)))
        else $error("payload on failed request");

    // input stalls only while a result is waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_occupancy)
         && $stable(o_out_address)))
        else $error("stalled result changed");

endmodule

bind per_source_request_queue_unit psrq_checker #(
    .DEPTH     (DEPTH),
    .CORE_BITS (CORE_BITS),
    .ADDR_BITS (ADDR_BITS),
    .TAG_BITS  (TAG_BITS)
) u_psrq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_out_core    (o_out_core),
    .o_out_address (o_out_address),
    .o_out_tag     (o_out_tag),
    .o_occupancy   (o_occupancy)
);

/* bench/tb_per_source_request_queue_unit.sv */
`timescale 1ns / 100ps

module tb_per_source_request_queue_unit
    import psrq_pkg::*;
();

    localparam int OCC_W = $clog2(DefDepth + 1);

    typedef struct packed {
        bit [DefCoreBits-1:0] core;
        bit [DefAddrBits-1:0] addr;
        bit [DefTagBits-1:0]  tag;
    } t_held_req;

    typedef struct packed {
        t_status              status;
        bit [DefCoreBits-1:0] core;
        bit [DefAddrBits-1:0] addr;
        bit [DefTagBits-1:0]  tag;
        bit [OCC_W-1:0]       occupancy;
    } t_queue_reply;

    class request_queue_mirror;
        t_held_req    held[$];
        t_queue_reply awaited[$];
        bit           strict;
        int           errors;

        function new();
            strict = 1'b0;
            errors = 0;
        endfunction

        function void set_strict(bit value);
            strict = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Position of the request that serves this core, -1 if none
        function int serving_slot(bit [DefCoreBits-1:0] core);
            if (held.size() == 0)
                return -1;
            if (strict)
                return (held[0].core == core) ? 0 : -1;
            foreach (held[i])
                if (held[i].core == core)
                    return i;
            return -1;
        endfunction

        // Core of a request now held, mostly the head in strict mode; a random core if empty
        function bit [DefCoreBits-1:0] held_core();
            if (held.size() == 0)
                return DefCoreBits'($urandom_range(0, (1 << DefCoreBits) - 1));
            if (strict && $urandom_range(0, 99) < 70)
                return held[0].core;
            return held[$urandom_range(0, held.size() - 1)].core;
        endfunction

        function void note_request(t_cmd cmd, bit [DefCoreBits-1:0] core,
                                   bit [DefAddrBits-1:0] addr, bit [DefTagBits-1:0] tag);
            t_queue_reply reply;
            t_held_req    entry;
            int           slot;
            reply.status = ST_DONE;
            reply.core   = '0;
            reply.addr   = '0;
            reply.tag    = '0;
            entry.core   = core;
            entry.addr   = addr;
            entry.tag    = tag;
            case (cmd)
                CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
                    if (held.size() >= DefDepth)
                        reply.status = ST_FULL;
                    else if (cmd == CMD_PUSH_HEAD)
                        held.insert(0, entry);
                    else
                        held.insert(held.size(), entry);
                end
                CMD_DEQUEUE: begin
                    slot = serving_slot(core);
                    if (slot < 0) begin
                        reply.status = ST_NONE;
                    end else begin
                        reply.core = held[slot].core;
                        reply.addr = held[slot].addr;
                        reply.tag  = held[slot].tag;
                        held.delete(slot);
                    end
                end
                default: begin
                    reply.status = (serving_slot(core) < 0) ? ST_NONE : ST_DONE;
                end
            endcase
            reply.occupancy = OCC_W'(held.size());
            awaited.insert(awaited.size(), reply);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [1:0] status, logic [DefCoreBits-1:0] core,
                                   logic [DefAddrBits-1:0] addr,
                                   logic [DefTagBits-1:0] tag,
                                   logic [OCC_W-1:0] occupancy);
            t_queue_reply want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, status %0h occupancy %0d",
                         $time, status, occupancy);
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            compare_field("status", 64'(want.status), 64'(status));
            compare_field("out_core", 64'(want.core), 64'(core));
            compare_field("out_address", 64'(want.addr), 64'(addr));
            compare_field("out_tag", 64'(want.tag), 64'(tag));
            compare_field("occupancy", 64'(want.occupancy), 64'(occupancy));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [1:0]             i_command;
    logic [DefCoreBits-1:0] i_core_id;
    logic [DefAddrBits-1:0] i_address;
    logic [DefTagBits-1:0]  i_msg_tag;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [1:0]             o_status;
    logic [DefCoreBits-1:0] o_out_core;
    logic [DefAddrBits-1:0] o_out_address;
    logic [DefTagBits-1:0]  o_out_tag;
    logic [OCC_W-1:0]       o_occupancy;

    request_queue_mirror mirror;
    int                  hold_requests;
    bit                  sender_gaps;
    bit                  rx_quiet;

    per_source_request_queue_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_core_id     (i_core_id),
        .i_address     (i_address),
        .i_msg_tag     (i_msg_tag),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_core    (o_out_core),
        .o_out_address (o_out_address),
        .o_out_tag     (o_out_tag),
        .o_occupancy   (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_per_source_request_queue_unit: errors");
        $finish;
    end

    // Receiver: random stalls, quiet stretches and a long hold-off on demand
    initial begin : receiver
        int hold_left;
        int holds_served;
        i_out_stall  = 1'b0;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.check_result(o_status, o_out_core, o_out_address, o_out_tag, o_occupancy);
    end

    task automatic send_request(t_cmd cmd, logic [DefCoreBits-1:0] core,
                                logic [DefAddrBits-1:0] addr, logic [DefTagBits-1:0] tag);
        while (sender_gaps && $urandom_range(0, 99) < 33) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_core_id  <= core;
        i_address  <= addr;
        i_msg_tag  <= tag;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        mirror.note_request(cmd, core, addr, tag);
    endtask

    // Drop valid and hold until every reply is back
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_strict(bit value);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        mirror.set_strict(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [DefAddrBits-1:0] pick_address();
        logic [63:0] wide;
        int          roll;
        roll = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (roll < 10)
            return '1;
        if (roll < 20)
            return '0;
        return wide[DefAddrBits-1:0];
    endfunction

    task automatic random_request(int push_weight);
        t_cmd                   cmd;
        logic [DefCoreBits-1:0] core;
        int                     roll;
        roll = $urandom_range(0, 99);
        if (roll < push_weight) begin
            cmd  = $urandom_range(0, 1) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
            // few cores so that dequeues and queries find matches
            core = ($urandom_range(0, 99) < 50) ? DefCoreBits'($urandom_range(0, 3))
                                                : DefCoreBits'($urandom_range(0, 15));
        end else begin
            cmd  = (roll < push_weight + (100 - push_weight) * 3 / 4) ? CMD_DEQUEUE
                                                                       : CMD_QUERY;
            core = ($urandom_range(0, 99) < 65) ? mirror.held_core()
                                                : DefCoreBits'($urandom_range(0, 15));
        end
        send_request(cmd, core, pick_address(), DefTagBits'($urandom_range(0, 255)));
    endtask

    task automatic run_random(int count, int hold_at, int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at)
                hold_requests++;
            if (n == pause_at)
                settle_idle();
            random_request(((n / 40) % 2) ? 35 : 65);
        end
    endtask

    initial begin
        mirror        = new();
        hold_requests = 0;
        sender_gaps   = 1'b1;
        rx_quiet      = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_QUERY;
        i_core_id     = '0;
        i_address     = '0;
        i_msg_tag     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue, extremes, fill to the brim, middle removal, misses
        send_request(CMD_QUERY, 4'd0, '0, '0);
        send_request(CMD_DEQUEUE, 4'd15, '0, '0);
        send_request(CMD_PUSH_TAIL, 4'd15, '1, 8'hff);
        send_request(CMD_PUSH_HEAD, 4'd0, '0, 8'h00);
        send_request(CMD_PUSH_TAIL, 4'd9, 48'h5555_5555_5555, 8'h55);
        send_request(CMD_PUSH_HEAD, 4'd6, 48'haaaa_aaaa_aaaa, 8'haa);
        for (int k = 0; k < 12; k++)
            send_request(k[0] ? CMD_PUSH_HEAD : CMD_PUSH_TAIL, DefCoreBits'(k % 4 + 1),
                         pick_address(), DefTagBits'($urandom_range(0, 255)));
        send_request(CMD_PUSH_TAIL, 4'd7, '1, 8'h11);
        send_request(CMD_PUSH_HEAD, 4'd7, '1, 8'h22);
        send_request(CMD_QUERY, 4'd9, '0, '0);
        send_request(CMD_DEQUEUE, 4'd9, '0, '0);
        send_request(CMD_DEQUEUE, 4'd13, '0, '0);
        send_request(CMD_QUERY, 4'd13, '0, '0);
        run_random(180, -1, 90);

        // Strict order: only the head may be served
        write_strict(1'b1);
        send_request(CMD_PUSH_HEAD, 4'd14, 48'h8000_0000_0001, 8'h80);
        send_request(CMD_QUERY, 4'd15, '0, '0);
        send_request(CMD_DEQUEUE, 4'd15, '0, '0);
        send_request(CMD_DEQUEUE, 4'd14, '0, '0);
        send_request(CMD_QUERY, 4'd14, '0, '0);
        run_random(180, 60, -1);

        // No idling on either side for a stretch
        write_strict(1'b0);
        sender_gaps = 1'b0;
        rx_quiet    = 1'b1;
        run_random(120, -1, -1);
        sender_gaps = 1'b1;
        rx_quiet    = 1'b0;
        run_random(80, -1, -1);

        write_strict(1'b1);
        run_random(170, -1, -1);
        write_strict(1'b0);
        run_random(170, 100, -1);

        settle_idle();
        repeat (4) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("tb_per_source_request_queue_unit: clean");
        else
            $display("tb_per_source_request_queue_unit: errors");
        $finish;
    end

endmodule
